### hw/rtl/aoe_pkg.sv
// ----------------------------------------------------------------------------
// aoe_pkg
// Shared widths, register reset values and register indexes of the ADC
// oversampling and filtering block.
// ----------------------------------------------------------------------------
package aoe_pkg;

  // Fixed field widths of the sample and reading beats.
  localparam int SAMPLE_W = 12;
  localparam int COUNT_W  = 12;
  localparam int MV_W     = 14;
  localparam int PCT_W    = 10;

  // Configuration register widths.
  localparam int WEIGHT_W = 17;
  localparam int SCALE_W  = 18;
  localparam int LIGHT_W  = 12;

  // APB-style configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [MV_W-1:0]     MV_MAX  = 14'd16383;
  localparam logic [PCT_W-1:0]    PCT_MAX = 10'd1000;

  // Reset values of the configuration registers.
  localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST   = 17'd13107;
  localparam logic [SCALE_W-1:0]  MV_SCALE_RST     = 18'd169005;
  localparam logic [MV_W-1:0]     BAT_EMPTY_RST    = 14'd3200;
  localparam logic [MV_W-1:0]     BAT_FULL_RST     = 14'd3700;
  localparam logic [LIGHT_W-1:0]  LIGHT_DARK_RST   = 12'd3673;
  localparam logic [LIGHT_W-1:0]  LIGHT_BRIGHT_RST = 12'd248;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_EMA_WEIGHT   = 3'd0,
    REG_MV_SCALE     = 3'd1,
    REG_BAT_EMPTY    = 3'd2,
    REG_BAT_FULL     = 3'd3,
    REG_LIGHT_DARK   = 3'd4,
    REG_LIGHT_BRIGHT = 3'd5
  } aoe_reg_e;

endpackage

### hw/rtl/aoe_if.sv
// ----------------------------------------------------------------------------
// aoe channel interfaces
// Valid/ready channels for sample pairs and for finished readings.
// ----------------------------------------------------------------------------
interface aoe_sample_if import aoe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] battery_sample;
  logic [SAMPLE_W-1:0] light_sample;

  modport source (output valid, battery_sample, light_sample, input ready);
  modport sink   (input valid, battery_sample, light_sample, output ready);
endinterface

interface aoe_reading_if import aoe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] battery_count_filtered;
  logic [COUNT_W-1:0] light_count_average;
  logic [MV_W-1:0]    battery_millivolts;
  logic [PCT_W-1:0]   battery_percent_tenths;
  logic [PCT_W-1:0]   light_percent_tenths;

  modport source (output valid, battery_count_filtered, light_count_average,
                  battery_millivolts, battery_percent_tenths, light_percent_tenths,
                  input ready);
  modport sink   (input valid, battery_count_filtered, light_count_average,
                  battery_millivolts, battery_percent_tenths, light_percent_tenths,
                  output ready);
endinterface

### hw/rtl/aoe_serial_mul.sv
// ----------------------------------------------------------------------------
// aoe_serial_mul
// Unsigned shift-add multiplier that consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module aoe_serial_mul #(
  parameter int XW = 20,
  parameter int YW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  input  logic [YW-1:0] y_i,
  output logic          done_o,
  output logic [XW+YW-1:0] prod_o
);

  localparam int CW = $clog2(YW);

  logic [XW-1:0] x_q;
  logic [XW-1:0] hi_q;
  logic [YW-1:0] lo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [XW:0]   sum;

  // The low half shifts out multiplier bits and takes in finished product bits.
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= x_i;
        hi_q   <= '0;
        lo_q   <= y_i;
        cnt_q  <= CW'(YW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q <= sum[XW:1];
        lo_q <= {sum[0], lo_q[YW-1:1]};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### hw/rtl/aoe_serial_div.sv
// ----------------------------------------------------------------------------
// aoe_serial_div
// Restoring divider that produces one quotient bit per cycle, most
// significant first. The dividend must stay below divisor * 2**QN.
// ----------------------------------------------------------------------------
module aoe_serial_div #(
  parameter int RW = 26,
  parameter int VW = 14,
  parameter int QN = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [QN-1:0] quo_o
);

  localparam int CW = $clog2(QN);

  logic [RW-1:0] rem_q;
  logic [RW-1:0] dsh_q;
  logic [QN-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic          fits;

  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i;
        dsh_q  <= RW'(divisor_i) << (QN - 1);
        quo_q  <= '0;
        cnt_q  <= CW'(QN - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[QN-2:0], fits};
        dsh_q <= dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/adc_oversample_ema_percent_top.sv
// ----------------------------------------------------------------------------
// adc_oversample_ema_percent_top
// Sample pairs are accepted one per cycle and summed; every
// SAMPLES_PER_READING-th pair closes a reading. The reading is then worked out
// by a shared bit-serial divider (both averages, both percent values) and a
// shared shift-add multiplier (two filter products, millivolt scaling), during
// which no sample is accepted; the divider yields QN = max(SAMPLE_BITS, 10)
// quotient bits. A percent value that is clamped or zero skips its divide,
// and the first reading after reset skips the two filter products. A finished
// reading waits in an output register, so sampling for the next reading goes
// on while it is pending. Configuration sits on an APB-style port at byte
// addresses 4*i and should be written only while idle.
// ----------------------------------------------------------------------------
module adc_oversample_ema_percent_top import aoe_pkg::*; #(
  parameter int SAMPLES_PER_READING = 16,
  parameter int SAMPLE_BITS         = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  aoe_sample_if.sink        sample_i,
  aoe_reading_if.source     reading_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SB      = SAMPLE_BITS;
  localparam int SPR     = SAMPLES_PER_READING;
  localparam int CNT_W   = $clog2(SPR);
  localparam int SUM_W   = SB + $clog2(SPR);
  localparam int IN_W    = (SB > SAMPLE_W) ? SB : SAMPLE_W;
  localparam int FILT_W  = SB + 8;
  localparam int MUL_YW  = SCALE_W;
  localparam int PROD_W  = FILT_W + MUL_YW;
  localparam int MVR_W   = SB + 2;
  localparam int PX      = (MVR_W > MV_W) ? MVR_W : MV_W;
  localparam int NUM_W   = PX + PCT_W;
  localparam int DIV_VW  = ($clog2(SPR + 1) > MV_W) ? $clog2(SPR + 1) : MV_W;
  localparam int DIV_QN  = (SB > PCT_W) ? SB : PCT_W;
  localparam int DIV_RW  = DIV_VW + DIV_QN;

  typedef enum logic [4:0] {
    S_ACC,
    S_AVGB_GO,
    S_AVGB_WT,
    S_AVGL_GO,
    S_AVGL_WT,
    S_EMA,
    S_EMA1_GO,
    S_EMA1_WT,
    S_EMA2_GO,
    S_EMA2_WT,
    S_MV_GO,
    S_MV_WT,
    S_PCTB,
    S_PCTB_WT,
    S_PCTL,
    S_PCTL_WT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              special;
    logic [PCT_W-1:0]  value;
    logic [DIV_RW-1:0] num;
    logic [DIV_VW-1:0] den;
  } pct_prep_t;

  // Configuration registers.
  logic [WEIGHT_W-1:0] ema_w_q;
  logic [SCALE_W-1:0]  mv_scale_q;
  logic [MV_W-1:0]     bat_empty_q;
  logic [MV_W-1:0]     bat_full_q;
  logic [LIGHT_W-1:0]  light_dark_q;
  logic [LIGHT_W-1:0]  light_bright_q;

  // Datapath and control registers.
  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    bat_sum_q;
  logic [SUM_W-1:0]    light_sum_q;
  logic [SB-1:0]       bat_avg_q;
  logic [SB-1:0]       light_avg_q;
  logic                primed_q;
  logic [FILT_W-1:0]   filt_q;
  logic [PROD_W-1:0]   p1_q;
  logic [MVR_W-1:0]    mv_q;
  logic [PCT_W-1:0]    bat_pct_q;
  logic [PCT_W-1:0]    light_pct_q;
  logic                out_valid_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [COUNT_W-1:0]  out_light_q;
  logic [MV_W-1:0]     out_mv_q;
  logic [PCT_W-1:0]    out_bat_pct_q;
  logic [PCT_W-1:0]    out_light_pct_q;

  logic                in_fire;
  logic                emit_fire;
  logic [IN_W-1:0]     bat_in_ext;
  logic [IN_W-1:0]     light_in_ext;
  logic [SB-1:0]       bat_s;
  logic [SB-1:0]       light_s;

  logic [WEIGHT_W-1:0] w_clip;
  logic [WEIGHT_W-1:0] w_inv;
  logic [PROD_W:0]     ema_sum;
  logic [PX-1:0]       mv_ext;
  logic [MV_W-1:0]     mv_sat;

  logic                mul_start;
  logic [FILT_W-1:0]   mul_x;
  logic [MUL_YW-1:0]   mul_y;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;

  logic                div_start;
  logic [DIV_RW-1:0]   div_num;
  logic [DIV_VW-1:0]   div_den;
  logic                div_done;
  logic [DIV_QN-1:0]   div_quo;

  logic [PX-1:0]       px_x;
  logic [PX-1:0]       px_z;
  logic [PX-1:0]       px_f;
  logic signed [PX:0]  diff;
  logic signed [PX:0]  span;
  logic [PX:0]         diff_abs;
  logic [PX:0]         span_abs;
  logic [PX-1:0]       dmag;
  logic [PX-1:0]       smag;
  logic [NUM_W-1:0]    num_full;
  pct_prep_t           prep;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_w_q        <= EMA_WEIGHT_RST;
      mv_scale_q     <= MV_SCALE_RST;
      bat_empty_q    <= BAT_EMPTY_RST;
      bat_full_q     <= BAT_FULL_RST;
      light_dark_q   <= LIGHT_DARK_RST;
      light_bright_q <= LIGHT_BRIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (aoe_reg_e'(paddr[APB_AW-1:2]))
        REG_EMA_WEIGHT:   ema_w_q        <= pwdata[WEIGHT_W-1:0];
        REG_MV_SCALE:     mv_scale_q     <= pwdata[SCALE_W-1:0];
        REG_BAT_EMPTY:    bat_empty_q    <= pwdata[MV_W-1:0];
        REG_BAT_FULL:     bat_full_q     <= pwdata[MV_W-1:0];
        REG_LIGHT_DARK:   light_dark_q   <= pwdata[LIGHT_W-1:0];
        REG_LIGHT_BRIGHT: light_bright_q <= pwdata[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (aoe_reg_e'(paddr[APB_AW-1:2]))
      REG_EMA_WEIGHT:   prdata = APB_DW'(ema_w_q);
      REG_MV_SCALE:     prdata = APB_DW'(mv_scale_q);
      REG_BAT_EMPTY:    prdata = APB_DW'(bat_empty_q);
      REG_BAT_FULL:     prdata = APB_DW'(bat_full_q);
      REG_LIGHT_DARK:   prdata = APB_DW'(light_dark_q);
      REG_LIGHT_BRIGHT: prdata = APB_DW'(light_bright_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  assign sample_i.ready = (state_q == S_ACC);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign bat_in_ext     = IN_W'(sample_i.battery_sample);
  assign light_in_ext   = IN_W'(sample_i.light_sample);
  assign bat_s          = bat_in_ext[SB-1:0];
  assign light_s        = light_in_ext[SB-1:0];

  // --------------------------------------------------------------------------
  // Filter and scaling arithmetic
  // --------------------------------------------------------------------------
  assign w_clip  = (ema_w_q > Q16_ONE) ? Q16_ONE : ema_w_q;
  assign w_inv   = Q16_ONE - w_clip;
  // old*(1-w) was kept from the first pass; the multiplier now holds avg*w.
  assign ema_sum = (PROD_W+1)'(p1_q) + ((PROD_W+1)'(mul_prod) << 8)
                 + (PROD_W+1)'(32768);
  assign mv_ext  = PX'(mv_q);
  assign mv_sat  = (mv_ext > PX'(MV_MAX)) ? MV_MAX : mv_ext[MV_W-1:0];

  assign mul_start = (state_q == S_EMA1_GO) || (state_q == S_EMA2_GO) ||
                     (state_q == S_MV_GO);

  always_comb begin
    unique case (state_q)
      S_EMA1_GO: begin
        mul_x = filt_q;
        mul_y = MUL_YW'(w_inv);
      end
      S_EMA2_GO: begin
        mul_x = FILT_W'(bat_avg_q);
        mul_y = MUL_YW'(w_clip);
      end
      default: begin
        mul_x = FILT_W'(filt_q[FILT_W-1:8]);
        mul_y = mv_scale_q;
      end
    endcase
  end

  aoe_serial_mul #(
    .XW (FILT_W),
    .YW (MUL_YW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Percent mapping set-up. A span of zero, a zero offset or an offset against
  // the direction of the span gives zero; an offset at or past the span gives
  // full scale. Only the remaining cases need the divider.
  // --------------------------------------------------------------------------
  always_comb begin
    if (state_q == S_PCTB) begin
      px_x = mv_ext;
      px_z = PX'(bat_empty_q);
      px_f = PX'(bat_full_q);
    end else begin
      px_x = PX'(light_avg_q);
      px_z = PX'(light_dark_q);
      px_f = PX'(light_bright_q);
    end
    diff     = $signed({1'b0, px_x}) - $signed({1'b0, px_z});
    span     = $signed({1'b0, px_f}) - $signed({1'b0, px_z});
    diff_abs = diff[PX] ? -diff : diff;
    span_abs = span[PX] ? -span : span;
    dmag     = diff_abs[PX-1:0];
    smag     = span_abs[PX-1:0];
    num_full = (NUM_W'(dmag) << 10) - (NUM_W'(dmag) << 4) - (NUM_W'(dmag) << 3);

    prep.num = DIV_RW'(num_full);
    prep.den = DIV_VW'(smag);
    if ((span == '0) || (diff == '0) || (diff[PX] != span[PX])) begin
      prep.special = 1'b1;
      prep.value   = '0;
    end else if (dmag >= smag) begin
      prep.special = 1'b1;
      prep.value   = PCT_MAX;
    end else begin
      prep.special = 1'b0;
      prep.value   = '0;
    end
  end

  assign div_start = (state_q == S_AVGB_GO) || (state_q == S_AVGL_GO) ||
                     (((state_q == S_PCTB) || (state_q == S_PCTL)) && !prep.special);

  always_comb begin
    unique case (state_q)
      S_AVGB_GO: begin
        div_num = DIV_RW'(bat_sum_q);
        div_den = DIV_VW'(SPR);
      end
      S_AVGL_GO: begin
        div_num = DIV_RW'(light_sum_q);
        div_den = DIV_VW'(SPR);
      end
      default: begin
        div_num = prep.num;
        div_den = prep.den;
      end
    endcase
  end

  aoe_serial_div #(
    .RW (DIV_RW),
    .VW (DIV_VW),
    .QN (DIV_QN)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || reading_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_ACC;
      cnt_q           <= '0;
      bat_sum_q       <= '0;
      light_sum_q     <= '0;
      bat_avg_q       <= '0;
      light_avg_q     <= '0;
      primed_q        <= 1'b0;
      filt_q          <= '0;
      p1_q            <= '0;
      mv_q            <= '0;
      bat_pct_q       <= '0;
      light_pct_q     <= '0;
      out_valid_q     <= 1'b0;
      out_count_q     <= '0;
      out_light_q     <= '0;
      out_mv_q        <= '0;
      out_bat_pct_q   <= '0;
      out_light_pct_q <= '0;
    end else begin
      if (reading_o.ready && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ACC: begin
          if (in_fire) begin
            bat_sum_q   <= bat_sum_q + SUM_W'(bat_s);
            light_sum_q <= light_sum_q + SUM_W'(light_s);
            if (cnt_q == CNT_W'(SPR - 1)) begin
              cnt_q   <= '0;
              state_q <= S_AVGB_GO;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_AVGB_GO: state_q <= S_AVGB_WT;
        S_AVGB_WT: begin
          if (div_done) begin
            bat_avg_q <= div_quo[SB-1:0];
            state_q   <= S_AVGL_GO;
          end
        end
        S_AVGL_GO: state_q <= S_AVGL_WT;
        S_AVGL_WT: begin
          if (div_done) begin
            light_avg_q <= div_quo[SB-1:0];
            bat_sum_q   <= '0;
            light_sum_q <= '0;
            state_q     <= S_EMA;
          end
        end
        S_EMA: begin
          if (primed_q) begin
            state_q <= S_EMA1_GO;
          end else begin
            // The first reading after reset loads the filter directly.
            filt_q   <= {bat_avg_q, 8'd0};
            primed_q <= 1'b1;
            state_q  <= S_MV_GO;
          end
        end
        S_EMA1_GO: state_q <= S_EMA1_WT;
        S_EMA1_WT: begin
          if (mul_done) begin
            p1_q    <= mul_prod;
            state_q <= S_EMA2_GO;
          end
        end
        S_EMA2_GO: state_q <= S_EMA2_WT;
        S_EMA2_WT: begin
          if (mul_done) begin
            filt_q  <= ema_sum[16 +: FILT_W];
            state_q <= S_MV_GO;
          end
        end
        S_MV_GO: state_q <= S_MV_WT;
        S_MV_WT: begin
          if (mul_done) begin
            mv_q    <= mul_prod[16 +: MVR_W];
            state_q <= S_PCTB;
          end
        end
        S_PCTB: begin
          if (prep.special) begin
            bat_pct_q <= prep.value;
            state_q   <= S_PCTL;
          end else begin
            state_q <= S_PCTB_WT;
          end
        end
        S_PCTB_WT: begin
          if (div_done) begin
            bat_pct_q <= div_quo[PCT_W-1:0];
            state_q   <= S_PCTL;
          end
        end
        S_PCTL: begin
          if (prep.special) begin
            light_pct_q <= prep.value;
            state_q     <= S_EMIT;
          end else begin
            state_q <= S_PCTL_WT;
          end
        end
        S_PCTL_WT: begin
          if (div_done) begin
            light_pct_q <= div_quo[PCT_W-1:0];
            state_q     <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Wait here only while an earlier reading still sits in the output.
          if (emit_fire) begin
            out_valid_q     <= 1'b1;
            out_count_q     <= COUNT_W'(filt_q[FILT_W-1:8]);
            out_light_q     <= COUNT_W'(light_avg_q);
            out_mv_q        <= mv_sat;
            out_bat_pct_q   <= bat_pct_q;
            out_light_pct_q <= light_pct_q;
            state_q         <= S_ACC;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  assign reading_o.valid                  = out_valid_q;
  assign reading_o.battery_count_filtered = out_count_q;
  assign reading_o.light_count_average    = out_light_q;
  assign reading_o.battery_millivolts     = out_mv_q;
  assign reading_o.battery_percent_tenths = out_bat_pct_q;
  assign reading_o.light_percent_tenths   = out_light_pct_q;

endmodule

### tb/aoe_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoe_reading_checker
// Watches the sample and reading channels and the configuration port, keeps
// its own model of the oversampling sums, the battery filter and the percent
// mapping, and compares every reading beat against the oldest prediction.
// ----------------------------------------------------------------------------
module aoe_reading_checker import aoe_pkg::*; #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  aoe_sample_if             sample_mon,
  aoe_reading_if            reading_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] bat_count;
    logic [COUNT_W-1:0] light_avg;
    logic [MV_W-1:0]    millivolts;
    logic [PCT_W-1:0]   bat_tenths;
    logic [PCT_W-1:0]   light_tenths;
  } reading_t;

  reading_t expected_readings[$];
  int unsigned errors;

  // Register copies, updated from the configuration writes seen on the port.
  logic [WEIGHT_W-1:0] ema_weight;
  logic [SCALE_W-1:0]  mv_scale;
  logic [MV_W-1:0]     bat_empty_mv;
  logic [MV_W-1:0]     bat_full_mv;
  logic [LIGHT_W-1:0]  light_dark;
  logic [LIGHT_W-1:0]  light_bright;

  logic [15:0] bat_sum;
  logic [15:0] light_sum;
  int          pairs_seen;
  logic [19:0] bat_filtered_q8;
  logic        filter_loaded;

  // Linear map to tenths of a percent, truncating toward zero, then clamped.
  function automatic logic [PCT_W-1:0] tenths_of(longint value, longint zero_pt,
                                                 longint full_pt);
    longint span;
    longint p;
    span = full_pt - zero_pt;
    if (span == 0) return '0;
    p = ((value - zero_pt) * 1000) / span;
    if (p < 0) p = 0;
    else if (p > longint'(PCT_MAX)) p = longint'(PCT_MAX);
    return p[PCT_W-1:0];
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic [COUNT_W-1:0] bat_avg;
    logic [COUNT_W-1:0] light_avg;
    longint unsigned    weight;
    longint unsigned    acc;
    longint unsigned    mv;
    reading_t           pred;
    reading_t           got;
    if (!rst_ni) begin
      ema_weight      = EMA_WEIGHT_RST;
      mv_scale        = MV_SCALE_RST;
      bat_empty_mv    = BAT_EMPTY_RST;
      bat_full_mv     = BAT_FULL_RST;
      light_dark      = LIGHT_DARK_RST;
      light_bright    = LIGHT_BRIGHT_RST;
      bat_sum         = '0;
      light_sum       = '0;
      pairs_seen      = 0;
      bat_filtered_q8 = '0;
      filter_loaded   = 1'b0;
      errors          = 0;
      expected_readings.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (aoe_reg_e'(paddr[APB_AW-1:2]))
          REG_EMA_WEIGHT:   ema_weight   = pwdata[WEIGHT_W-1:0];
          REG_MV_SCALE:     mv_scale     = pwdata[SCALE_W-1:0];
          REG_BAT_EMPTY:    bat_empty_mv = pwdata[MV_W-1:0];
          REG_BAT_FULL:     bat_full_mv  = pwdata[MV_W-1:0];
          REG_LIGHT_DARK:   light_dark   = pwdata[LIGHT_W-1:0];
          REG_LIGHT_BRIGHT: light_bright = pwdata[LIGHT_W-1:0];
          default: ;
        endcase
      end

      if (sample_mon.valid && sample_mon.ready) begin
        bat_sum    = bat_sum + sample_mon.battery_sample;
        light_sum  = light_sum + sample_mon.light_sample;
        pairs_seen = pairs_seen + 1;
        if (pairs_seen == SAMPLES_PER_READING) begin
          bat_avg    = COUNT_W'(bat_sum / SAMPLES_PER_READING);
          light_avg  = COUNT_W'(light_sum / SAMPLES_PER_READING);
          bat_sum    = '0;
          light_sum  = '0;
          pairs_seen = 0;
          if (!filter_loaded) begin
            bat_filtered_q8 = {bat_avg, 8'h00};
            filter_loaded   = 1'b1;
          end else begin
            // A weight above one behaves as exactly one.
            weight = (ema_weight > Q16_ONE) ? 65536 : ema_weight;
            acc = longint'(bat_filtered_q8) * (65536 - weight)
                + (longint'(bat_avg) << 8) * weight + 32768;
            bat_filtered_q8 = acc[35:16];
          end
          pred.bat_count = bat_filtered_q8[19:8];
          mv = (longint'(pred.bat_count) * longint'(mv_scale)) >> 16;
          pred.light_avg    = light_avg;
          pred.millivolts   = (mv > MV_MAX) ? MV_MAX : mv[MV_W-1:0];
          // Battery percent is taken from the millivolts before saturation.
          pred.bat_tenths   = tenths_of(mv, bat_empty_mv, bat_full_mv);
          pred.light_tenths = tenths_of(light_avg, light_dark, light_bright);
          expected_readings.push_back(pred);
        end
      end

      if (reading_mon.valid && reading_mon.ready) begin
        got.bat_count    = reading_mon.battery_count_filtered;
        got.light_avg    = reading_mon.light_count_average;
        got.millivolts   = reading_mon.battery_millivolts;
        got.bat_tenths   = reading_mon.battery_percent_tenths;
        got.light_tenths = reading_mon.light_percent_tenths;
        if (expected_readings.size() == 0) begin
          $display("%0t: reading beat expected none, actual count %0d light %0d mv %0d %0d %0d",
                   $time, got.bat_count, got.light_avg, got.millivolts, got.bat_tenths,
                   got.light_tenths);
          errors++;
        end else begin
          pred = expected_readings.pop_front();
          check_field("battery_count_filtered", pred.bat_count, got.bat_count);
          check_field("light_count_average", pred.light_avg, got.light_avg);
          check_field("battery_millivolts", pred.millivolts, got.millivolts);
          check_field("battery_percent_tenths", pred.bat_tenths, got.bat_tenths);
          check_field("light_percent_tenths", pred.light_tenths, got.light_tenths);
        end
      end

      errors_o  <= errors;
      pending_o <= expected_readings.size();
    end
  end

endmodule

### tb/adc_oversample_ema_percent_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_oversample_ema_percent_top_tb
// Drives sample pairs and configuration writes into the block, with random
// gaps on both channels and one long output stall, and leaves prediction and
// comparison of the readings to the checker placed beside the block.
// ----------------------------------------------------------------------------
module adc_oversample_ema_percent_top_tb import aoe_pkg::*; ();

  localparam int PAIRS_PER_READING = 16;
  localparam int READING_LATENCY   = 200;
  localparam int TIMEOUT_CYCLES    = 300000;
  localparam int PAIRS_PER_PHASE   = 80;
  localparam int PHASES            = 10;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned readings_pending;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_request;
  int          cycle_count;

  aoe_sample_if  sample_ch ();
  aoe_reading_if reading_ch ();

  adc_oversample_ema_percent_top #(
    .SAMPLES_PER_READING(PAIRS_PER_READING),
    .SAMPLE_BITS        (SAMPLE_W)
  ) uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .reading_o(reading_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  aoe_reading_checker #(
    .SAMPLES_PER_READING(PAIRS_PER_READING)
  ) u_reading_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_mon (sample_ch),
    .reading_mon(reading_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .errors_o   (mismatches),
    .pending_o  (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("adc_oversample_ema_percent_top_tb: FAIL");
    $finish;
  end

  // Reading sink: random back-pressure, plus one long hold-off on request.
  initial begin : reading_sink
    int hold_left;
    hold_left = 0;
    reading_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        reading_ch.ready <= 1'b0;
      end else begin
        reading_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // Valid stays high from one beat to the next unless a gap is drawn.
  task automatic send_pair(logic [SAMPLE_W-1:0] bat, logic [SAMPLE_W-1:0] light);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.battery_sample <= bat;
    sample_ch.light_sample   <= light;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic apb_write(aoe_reg_e idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted reading has come out and the block is quiet.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
    repeat (READING_LATENCY) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [APB_DW-1:0]   cfg [6];
    aoe_reg_e            r;
    int                  bat_level;
    int                  light_level;
    int                  style;
    logic [SAMPLE_W-1:0] bat;
    logic [SAMPLE_W-1:0] light;

    rst_n        = 1'b0;
    src_idle_pct = 11;
    snk_idle_pct = 66;
    hold_request = 1'b0;
    bat_level    = 0;
    light_level  = 0;
    style        = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.battery_sample <= '0;
    sample_ch.light_sample   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first reading loads the filter directly at full scale; light at
    // zero lands above the reversed span and clamps high. The second runs
    // the filter and clamps light low.
    repeat (PAIRS_PER_READING) send_pair(12'd4095, 12'd0);
    repeat (PAIRS_PER_READING) send_pair(12'd0, 12'd4095);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase < 4) begin
        src_idle_pct = 11;
        snk_idle_pct = 66;
      end else if (phase < 7) begin
        src_idle_pct = 66;
        snk_idle_pct = 11;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      // Register order: ema, scale, empty, full, dark, bright.
      case (phase)
        1: cfg = '{32'd65536, 32'd169005, 32'd3200, 32'd3700, 32'd0, 32'd4095};
        2: cfg = '{32'd0, 32'd262143, 32'd0, 32'd16383, 32'd4095, 32'd0};
        3: cfg = '{32'd131071, 32'd0, 32'd3700, 32'd3200, 32'd1000, 32'd1000};
        4: cfg = '{32'd32768, 32'd100000, 32'd2000, 32'd2000, 32'd248, 32'd3673};
        5: cfg = '{32'd1, 32'd131072, 32'd16383, 32'd0, 32'd2048, 32'd2047};
        6: cfg = '{32'd65535, 32'd200000, 32'd1000, 32'd10000, 32'd3673, 32'd248};
        7: cfg = '{32'd13107, 32'd169005, 32'd3200, 32'd3700, 32'd3673, 32'd248};
        default: begin
          cfg[REG_EMA_WEIGHT]   = $urandom_range(131071);
          cfg[REG_MV_SCALE]     = $urandom_range(262143);
          cfg[REG_BAT_EMPTY]    = $urandom_range(16383);
          cfg[REG_BAT_FULL]     = $urandom_range(16383);
          cfg[REG_LIGHT_DARK]   = $urandom_range(4095);
          cfg[REG_LIGHT_BRIGHT] = $urandom_range(4095);
        end
      endcase
      // The first phase runs on the reset values.
      if (phase != 0) begin
        r = r.first();
        repeat (r.num()) begin
          apb_write(r, cfg[r]);
          r = r.next();
        end
      end

      if (phase == 7) hold_request = 1'b1;

      for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
        if (i % PAIRS_PER_READING == 0) begin
          bat_level   = $urandom_range(1000, 1700);
          light_level = $urandom_range(4095);
          style       = $urandom_range(3);
        end
        case (style)
          0: begin
            bat   = SAMPLE_W'($urandom_range(4095));
            light = SAMPLE_W'($urandom_range(4095));
          end
          1: begin
            bat   = $urandom_range(1) ? 12'd4095 : 12'd0;
            light = $urandom_range(1) ? 12'd4095 : 12'd0;
          end
          default: begin
            // Samples scattered around one level keep the averages near it, so they
            // can land inside the percent spans rather than at the clamps.
            bat   = clamp_sample(bat_level + int'($urandom_range(80)) - 40);
            light = clamp_sample(light_level + int'($urandom_range(200)) - 100);
          end
        endcase
        send_pair(bat, light);
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("adc_oversample_ema_percent_top_tb: PASS");
    end else begin
      $display("adc_oversample_ema_percent_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### adc_oversample_ema_percent_top.f
hw/rtl/aoe_pkg.sv
hw/rtl/aoe_if.sv
hw/rtl/aoe_serial_mul.sv
hw/rtl/aoe_serial_div.sv
hw/rtl/adc_oversample_ema_percent_top.sv
tb/aoe_reading_checker.sv
tb/adc_oversample_ema_percent_top_tb.sv
